>>> rtl/core/sdce_pkg.sv
// shared types, constants and term classification for the sh degree-3 color evaluator
`timescale 1ns / 1ps
package sdce_pkg;

  // field widths
  localparam int DIR_W   = 16;
  localparam int COEF_W  = 16;
  localparam int TERM_W  = 4;
  localparam int COLOR_W = 22;
  localparam int SUM_W   = 32;

  // fixed-point formats
  localparam int DIR_FRAC  = 14;
  localparam int COEF_FRAC = 12;
  localparam int SHK_FRAC  = 16;
  localparam int K_W       = 18;

  // datapath widths
  localparam int SQ_W    = 32;  // squares and cross products
  localparam int Q_W     = 35;  // quadratic factor
  localparam int P_W     = 51;  // exact polynomial
  localparam int PR_W    = 23;  // polynomial rounded to DIR_FRAC
  localparam int KS_W    = K_W + 1;
  localparam int PROD_W  = PR_W + KS_W;
  localparam int BASIS_W = 27;
  localparam int CPROD_W = COEF_W + BASIS_W;

  localparam int SH_DEG2 = DIR_FRAC;
  localparam int SH_DEG3 = 2 * DIR_FRAC;

  localparam logic signed [P_W-1:0]     P_ONE   = P_W'(1) <<< DIR_FRAC;
  localparam logic signed [P_W:0]       RND_D2  = (P_W + 1)'(1) <<< (SH_DEG2 - 1);
  localparam logic signed [P_W:0]       RND_D3  = (P_W + 1)'(1) <<< (SH_DEG3 - 1);
  localparam logic signed [PROD_W:0]    RND_K   = (PROD_W + 1)'(1) <<< (SHK_FRAC - 1);
  localparam logic signed [CPROD_W:0]   RND_C   = (CPROD_W + 1)'(1) <<< (DIR_FRAC - 1);
  localparam logic signed [SUM_W+1:0]   SUM_MAX = (SUM_W + 2)'((64'sd1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W+1:0]   SUM_MIN = -((SUM_W + 2)'(1) <<< (SUM_W - 1));
  localparam logic signed [SUM_W:0]     OUT_HALF = (SUM_W + 1)'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SUM_W:0]     OUT_MAX = ((SUM_W + 1)'(1) <<< (COLOR_W - 1)) - 1;
  localparam logic signed [SUM_W:0]     OUT_MIN = -((SUM_W + 1)'(1) <<< (COLOR_W - 1));

  // polynomial degree
  localparam logic [1:0] DEG0 = 2'd0;
  localparam logic [1:0] DEG1 = 2'd1;
  localparam logic [1:0] DEG2 = 2'd2;
  localparam logic [1:0] DEG3 = 2'd3;

  // linear factor
  localparam logic [1:0] F_X = 2'd0;
  localparam logic [1:0] F_Y = 2'd1;
  localparam logic [1:0] F_Z = 2'd2;

  // quadratic factor
  localparam logic [3:0] Q_XY          = 4'd0;
  localparam logic [3:0] Q_YZ          = 4'd1;
  localparam logic [3:0] Q_XZ          = 4'd2;
  localparam logic [3:0] Q_ZZ2_XX_YY   = 4'd3;
  localparam logic [3:0] Q_XX_YY       = 4'd4;
  localparam logic [3:0] Q_XX3_YY      = 4'd5;
  localparam logic [3:0] Q_ZZ4_XX_YY   = 4'd6;
  localparam logic [3:0] Q_ZZ2_XX3_YY3 = 4'd7;
  localparam logic [3:0] Q_XX_YY3      = 4'd8;

  // basis constant magnitudes, unsigned Q2.16
  localparam logic [K_W-1:0] K_C0  = 18'd18487;
  localparam logic [K_W-1:0] K_C1  = 18'd32021;
  localparam logic [K_W-1:0] K_C20 = 18'd71601;
  localparam logic [K_W-1:0] K_C22 = 18'd20670;
  localparam logic [K_W-1:0] K_C24 = 18'd35801;
  localparam logic [K_W-1:0] K_C30 = 18'd38669;
  localparam logic [K_W-1:0] K_C31 = 18'd189439;
  localparam logic [K_W-1:0] K_C32 = 18'd29953;
  localparam logic [K_W-1:0] K_C33 = 18'd24456;
  localparam logic [K_W-1:0] K_C35 = 18'd94720;

  typedef struct packed {
    logic [1:0]     deg;
    logic           neg;
    logic [1:0]     f_sel;
    logic [3:0]     q_sel;
    logic [K_W-1:0] k;
  } term_class_t;

  typedef struct packed {
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;
    logic signed [COEF_W-1:0] coef_red;
    logic signed [COEF_W-1:0] coef_green;
    logic signed [COEF_W-1:0] coef_blue;
    logic                     last;
    term_class_t              cls;
  } item_t;

  typedef struct packed {
    logic signed [COLOR_W-1:0] red;
    logic signed [COLOR_W-1:0] green;
    logic signed [COLOR_W-1:0] blue;
    logic                      saturated;
  } result_t;

  function automatic term_class_t classify(input logic [TERM_W-1:0] term);
    term_class_t c;
    unique case (term)
      4'd0:  c = '{DEG0, 1'b0, F_X, Q_XY,          K_C0};
      4'd1:  c = '{DEG1, 1'b1, F_Y, Q_XY,          K_C1};
      4'd2:  c = '{DEG1, 1'b0, F_Z, Q_XY,          K_C1};
      4'd3:  c = '{DEG1, 1'b1, F_X, Q_XY,          K_C1};
      4'd4:  c = '{DEG2, 1'b0, F_X, Q_XY,          K_C20};
      4'd5:  c = '{DEG2, 1'b1, F_X, Q_YZ,          K_C20};
      4'd6:  c = '{DEG2, 1'b0, F_X, Q_ZZ2_XX_YY,   K_C22};
      4'd7:  c = '{DEG2, 1'b1, F_X, Q_XZ,          K_C20};
      4'd8:  c = '{DEG2, 1'b0, F_X, Q_XX_YY,       K_C24};
      4'd9:  c = '{DEG3, 1'b1, F_Y, Q_XX3_YY,      K_C30};
      4'd10: c = '{DEG3, 1'b0, F_Z, Q_XY,          K_C31};
      4'd11: c = '{DEG3, 1'b1, F_Y, Q_ZZ4_XX_YY,   K_C32};
      4'd12: c = '{DEG3, 1'b0, F_Z, Q_ZZ2_XX3_YY3, K_C33};
      4'd13: c = '{DEG3, 1'b1, F_X, Q_ZZ4_XX_YY,   K_C32};
      4'd14: c = '{DEG3, 1'b0, F_Z, Q_XX_YY,       K_C35};
      4'd15: c = '{DEG3, 1'b1, F_X, Q_XX_YY3,      K_C30};
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/sh_degree3_color_eval.sv
// top level of the degree-3 spherical-harmonic color evaluator
`timescale 1ns / 1ps
// Usage: each input transfer carries a view direction (Q1.14), one basis term index
// and that term's rgb coefficients (Q3.12). Terms of one evaluation are pushed in any
// order; the transfer with last_term set closes the evaluation and yields one result:
// the three channel sums plus 0.5, clamped to Q9.12, with saturated set if any clamped.
// Input side: push/full. Result side: empty/pop, the oldest result sits on the ports
// while empty is low.
// Throughput: one term per cycle while no last term waits for a result slot, set by
// the term queue and the 8-stage back pipeline, whose accumulators take one term
// each cycle. Path: a last term passes the term queue, 7 datapath stages and
// 1 accumulate stage; its result is then written into the result queue.
// Stall: results wait in a RESULT_DEPTH queue; the back end only starts a last term
// when a slot is reserved for it, so a receiver that stops popping backs up the term
// queue and raises full, and no item is lost.
// Reset: rst clears both queues, the pipeline valids and the accumulators.
module sh_degree3_color_eval #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  output logic                                      full,
  input  logic signed [sdce_pkg::DIR_W-1:0]         dir_x,
  input  logic signed [sdce_pkg::DIR_W-1:0]         dir_y,
  input  logic signed [sdce_pkg::DIR_W-1:0]         dir_z,
  input  logic        [sdce_pkg::TERM_W-1:0]        term_index,
  input  logic signed [sdce_pkg::COEF_W-1:0]        coef_red,
  input  logic signed [sdce_pkg::COEF_W-1:0]        coef_green,
  input  logic signed [sdce_pkg::COEF_W-1:0]        coef_blue,
  input  logic                                      last_term,
  input  logic                                      pop,
  output logic                                      empty,
  output logic signed [sdce_pkg::COLOR_W-1:0]       color_red,
  output logic signed [sdce_pkg::COLOR_W-1:0]       color_green,
  output logic signed [sdce_pkg::COLOR_W-1:0]       color_blue,
  output logic                                      saturated
);
  localparam int RW = $bits(sdce_pkg::result_t);

  sdce_pkg::item_t                     item;
  logic                                item_empty;
  logic                                item_pop;
  logic [$clog2(RESULT_DEPTH+1)-1:0]   res_count;
  logic                                res_push;
  sdce_pkg::result_t                   res_in;
  logic [RW-1:0]                       res_bits;
  logic                                res_full;
  sdce_pkg::result_t                   res_out;

  sdce_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .term_index (term_index),
    .coef_red   (coef_red),
    .coef_green (coef_green),
    .coef_blue  (coef_blue),
    .last_term  (last_term),
    .item_pop   (item_pop),
    .item_empty (item_empty),
    .item       (item)
  );

  sdce_back #(
    .OUT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .out_count  (res_count),
    .res_push   (res_push),
    .res        (res_in)
  );

  sdce_queue #(
    .WIDTH (RW),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty),
    .count (res_count)
  );

  assign res_out     = sdce_pkg::result_t'(res_bits);
  assign color_red   = res_out.red;
  assign color_green = res_out.green;
  assign color_blue  = res_out.blue;
  assign saturated   = res_out.saturated;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");
endmodule

>>> rtl/core/sdce_queue.sv
// small first-in first-out queue held in flip-flops
`timescale 1ns / 1ps
module sdce_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

>>> rtl/core/sdce_front.sv
// front end: accepts term items, decodes the basis term and queues them
`timescale 1ns / 1ps
module sdce_front #(
  parameter int DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sdce_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [sdce_pkg::DIR_W-1:0]   dir_y,
  input  logic signed [sdce_pkg::DIR_W-1:0]   dir_z,
  input  logic        [sdce_pkg::TERM_W-1:0]  term_index,
  input  logic signed [sdce_pkg::COEF_W-1:0]  coef_red,
  input  logic signed [sdce_pkg::COEF_W-1:0]  coef_green,
  input  logic signed [sdce_pkg::COEF_W-1:0]  coef_blue,
  input  logic                                last_term,
  input  logic                                item_pop,
  output logic                                item_empty,
  output sdce_pkg::item_t                     item
);
  localparam int IW = $bits(sdce_pkg::item_t);
  localparam int FW = $clog2(DEPTH + 1);

  sdce_pkg::item_t           item_in;
  logic [IW-1:0]             item_bits;
  logic [FW-1:0]             fill;

  always_comb begin
    item_in.dir_x      = dir_x;
    item_in.dir_y      = dir_y;
    item_in.dir_z      = dir_z;
    item_in.coef_red   = coef_red;
    item_in.coef_green = coef_green;
    item_in.coef_blue  = coef_blue;
    item_in.last       = last_term;
    item_in.cls        = sdce_pkg::classify(term_index);
  end

  sdce_queue #(
    .WIDTH (IW),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item_bits),
    .empty (item_empty),
    .count (fill)
  );

  assign item = sdce_pkg::item_t'(item_bits);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("term queue fill above depth");
endmodule

>>> rtl/core/sdce_back.sv
// back end: basis polynomial, constant scaling, coefficient products and accumulation
`timescale 1ns / 1ps
module sdce_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sdce_pkg::item_t                     item,
  input  logic                                item_empty,
  output logic                                item_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
  output logic                                res_push,
  output sdce_pkg::result_t                   res
);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam int DW = sdce_pkg::DIR_W;
  localparam int CW = sdce_pkg::COEF_W;
  localparam int SW = sdce_pkg::SUM_W;

  typedef struct packed {
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] g;
    logic signed [CW-1:0] b;
    logic                 last;
  } coef_t;

  // launch control
  logic              go;
  logic [OCNT_W-1:0] inflight;
  logic [OCNT_W-1:0] inflight_next;
  logic [OCNT_W:0]   credit_used;

  // stage valids
  logic v1, v2, v3, v4, v5, v6, v7, fin_valid;

  // stage 1: squares and cross products
  logic signed [sdce_pkg::SQ_W-1:0] s1_xx, s1_yy, s1_zz, s1_xy, s1_yz, s1_xz;
  logic signed [DW-1:0]             s1_f;
  sdce_pkg::term_class_t            s1_cls;
  coef_t                            s1_c;
  logic signed [sdce_pkg::SQ_W-1:0] xe, ye, ze;

  // stage 2: quadratic factor
  logic signed [sdce_pkg::Q_W-1:0]  s2_q;
  logic signed [DW-1:0]             s2_f;
  sdce_pkg::term_class_t            s2_cls;
  coef_t                            s2_c;
  logic signed [sdce_pkg::Q_W-1:0]  q_next;
  logic signed [sdce_pkg::Q_W-1:0]  qxx, qyy, qzz;

  // stage 3: exact polynomial
  logic signed [sdce_pkg::P_W-1:0]  s3_p;
  sdce_pkg::term_class_t            s3_cls;
  coef_t                            s3_c;
  logic signed [sdce_pkg::P_W-1:0]  p_next;

  // stage 4: rounded polynomial and signed constant
  logic signed [sdce_pkg::PR_W-1:0] s4_pr;
  logic signed [sdce_pkg::KS_W-1:0] s4_k;
  coef_t                            s4_c;
  logic signed [sdce_pkg::P_W:0]    r2_sum, r3_sum, r2_sh, r3_sh;
  logic signed [sdce_pkg::PR_W-1:0] pr_next;
  logic signed [sdce_pkg::KS_W-1:0] k_pos;

  // stage 5: constant product
  logic signed [sdce_pkg::PROD_W-1:0] s5_prod;
  coef_t                              s5_c;

  // stage 6: basis value
  logic signed [sdce_pkg::BASIS_W-1:0] s6_basis;
  coef_t                               s6_c;
  logic signed [sdce_pkg::PROD_W:0]    b_sum, b_sh;

  // stage 7: coefficient products
  logic signed [sdce_pkg::CPROD_W-1:0] s7_r, s7_g, s7_b;
  logic                                s7_last;

  // accumulators and finished sums
  logic signed [SW-1:0] sum_red, sum_green, sum_blue;
  logic signed [SW-1:0] new_red, new_green, new_blue;
  logic signed [SW-1:0] fin_red, fin_green, fin_blue;
  logic [sdce_pkg::COLOR_W:0] out_r, out_g, out_b;

  function automatic logic signed [SW-1:0] acc_add(
    input logic signed [SW-1:0]                s,
    input logic signed [sdce_pkg::CPROD_W-1:0] cp
  );
    logic signed [sdce_pkg::CPROD_W:0] rs;
    logic signed [sdce_pkg::CPROD_W:0] rsh;
    logic signed [SW+1:0]              t;
    rs  = (sdce_pkg::CPROD_W + 1)'(cp) + sdce_pkg::RND_C;
    rsh = rs >>> sdce_pkg::DIR_FRAC;
    t   = (SW + 2)'(s) + (SW + 2)'(rsh);
    if (t > sdce_pkg::SUM_MAX) begin
      return sdce_pkg::SUM_MAX[SW-1:0];
    end else if (t < sdce_pkg::SUM_MIN) begin
      return sdce_pkg::SUM_MIN[SW-1:0];
    end
    return t[SW-1:0];
  endfunction

  // returns {clamped, value}
  function automatic logic [sdce_pkg::COLOR_W:0] out_clamp(input logic signed [SW-1:0] s);
    logic signed [SW:0] v;
    v = (SW + 1)'(s) + sdce_pkg::OUT_HALF;
    if (v > sdce_pkg::OUT_MAX) begin
      return {1'b1, sdce_pkg::OUT_MAX[sdce_pkg::COLOR_W-1:0]};
    end else if (v < sdce_pkg::OUT_MIN) begin
      return {1'b1, sdce_pkg::OUT_MIN[sdce_pkg::COLOR_W-1:0]};
    end
    return {1'b0, v[sdce_pkg::COLOR_W-1:0]};
  endfunction

  // a last item only launches when a result slot is reserved for it
  assign credit_used = {1'b0, out_count} + {1'b0, inflight};
  assign go = !item_empty && (!item.last || (credit_used < (OCNT_W + 1)'(OUT_DEPTH)));
  assign item_pop = go;

  always_comb begin
    inflight_next = inflight;
    if (go && item.last && !fin_valid) begin
      inflight_next = inflight + OCNT_W'(1);
    end else if (!(go && item.last) && fin_valid) begin
      inflight_next = inflight - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      fin_valid <= 1'b0;
      inflight  <= '0;
    end else begin
      v1        <= go;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      fin_valid <= v7 && s7_last;
      inflight  <= inflight_next;
    end
  end

  // stage 1
  assign xe = sdce_pkg::SQ_W'(item.dir_x);
  assign ye = sdce_pkg::SQ_W'(item.dir_y);
  assign ze = sdce_pkg::SQ_W'(item.dir_z);

  always_ff @(posedge clk) begin
    s1_xx  <= xe * xe;
    s1_yy  <= ye * ye;
    s1_zz  <= ze * ze;
    s1_xy  <= xe * ye;
    s1_yz  <= ye * ze;
    s1_xz  <= xe * ze;
    s1_cls <= item.cls;
    s1_c   <= '{item.coef_red, item.coef_green, item.coef_blue, item.last};
    unique case (item.cls.f_sel)
      sdce_pkg::F_Y: s1_f <= item.dir_y;
      sdce_pkg::F_Z: s1_f <= item.dir_z;
      default:       s1_f <= item.dir_x;
    endcase
  end

  // stage 2
  assign qxx = sdce_pkg::Q_W'(s1_xx);
  assign qyy = sdce_pkg::Q_W'(s1_yy);
  assign qzz = sdce_pkg::Q_W'(s1_zz);

  always_comb begin
    unique case (s1_cls.q_sel)
      sdce_pkg::Q_YZ:          q_next = sdce_pkg::Q_W'(s1_yz);
      sdce_pkg::Q_XZ:          q_next = sdce_pkg::Q_W'(s1_xz);
      sdce_pkg::Q_ZZ2_XX_YY:   q_next = (qzz <<< 1) - qxx - qyy;
      sdce_pkg::Q_XX_YY:       q_next = qxx - qyy;
      sdce_pkg::Q_XX3_YY:      q_next = (qxx <<< 1) + qxx - qyy;
      sdce_pkg::Q_ZZ4_XX_YY:   q_next = (qzz <<< 2) - qxx - qyy;
      sdce_pkg::Q_ZZ2_XX3_YY3: q_next = (qzz <<< 1) - (qxx <<< 1) - qxx - (qyy <<< 1) - qyy;
      sdce_pkg::Q_XX_YY3:      q_next = qxx - (qyy <<< 1) - qyy;
      default:                 q_next = sdce_pkg::Q_W'(s1_xy);
    endcase
  end

  always_ff @(posedge clk) begin
    s2_q   <= q_next;
    s2_f   <= s1_f;
    s2_cls <= s1_cls;
    s2_c   <= s1_c;
  end

  // stage 3
  always_comb begin
    unique case (s2_cls.deg)
      sdce_pkg::DEG0: p_next = sdce_pkg::P_ONE;
      sdce_pkg::DEG1: p_next = sdce_pkg::P_W'(s2_f);
      sdce_pkg::DEG2: p_next = sdce_pkg::P_W'(s2_q);
      default:        p_next = sdce_pkg::P_W'(s2_f) * sdce_pkg::P_W'(s2_q);
    endcase
  end

  always_ff @(posedge clk) begin
    s3_p   <= p_next;
    s3_cls <= s2_cls;
    s3_c   <= s2_c;
  end

  // stage 4: round half up back to direction fraction bits
  assign r2_sum = (sdce_pkg::P_W + 1)'(s3_p) + sdce_pkg::RND_D2;
  assign r3_sum = (sdce_pkg::P_W + 1)'(s3_p) + sdce_pkg::RND_D3;
  assign r2_sh  = r2_sum >>> sdce_pkg::SH_DEG2;
  assign r3_sh  = r3_sum >>> sdce_pkg::SH_DEG3;
  assign k_pos  = $signed({1'b0, s3_cls.k});

  always_comb begin
    unique case (s3_cls.deg)
      sdce_pkg::DEG2: pr_next = r2_sh[sdce_pkg::PR_W-1:0];
      sdce_pkg::DEG3: pr_next = r3_sh[sdce_pkg::PR_W-1:0];
      default:        pr_next = s3_p[sdce_pkg::PR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    s4_pr <= pr_next;
    s4_k  <= s3_cls.neg ? -k_pos : k_pos;
    s4_c  <= s3_c;
  end

  // stage 5
  always_ff @(posedge clk) begin
    s5_prod <= sdce_pkg::PROD_W'(s4_pr) * sdce_pkg::PROD_W'(s4_k);
    s5_c    <= s4_c;
  end

  // stage 6
  assign b_sum = (sdce_pkg::PROD_W + 1)'(s5_prod) + sdce_pkg::RND_K;
  assign b_sh  = b_sum >>> sdce_pkg::SHK_FRAC;

  always_ff @(posedge clk) begin
    s6_basis <= b_sh[sdce_pkg::BASIS_W-1:0];
    s6_c     <= s5_c;
  end

  // stage 7
  always_ff @(posedge clk) begin
    s7_r    <= sdce_pkg::CPROD_W'(s6_c.r) * sdce_pkg::CPROD_W'(s6_basis);
    s7_g    <= sdce_pkg::CPROD_W'(s6_c.g) * sdce_pkg::CPROD_W'(s6_basis);
    s7_b    <= sdce_pkg::CPROD_W'(s6_c.b) * sdce_pkg::CPROD_W'(s6_basis);
    s7_last <= s6_c.last;
  end

  // accumulate
  assign new_red   = acc_add(sum_red, s7_r);
  assign new_green = acc_add(sum_green, s7_g);
  assign new_blue  = acc_add(sum_blue, s7_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
    end else if (v7) begin
      if (s7_last) begin
        sum_red   <= '0;
        sum_green <= '0;
        sum_blue  <= '0;
      end else begin
        sum_red   <= new_red;
        sum_green <= new_green;
        sum_blue  <= new_blue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v7 && s7_last) begin
      fin_red   <= new_red;
      fin_green <= new_green;
      fin_blue  <= new_blue;
    end
  end

  // output offset and clamp
  assign out_r = out_clamp(fin_red);
  assign out_g = out_clamp(fin_green);
  assign out_b = out_clamp(fin_blue);

  assign res_push      = fin_valid;
  assign res.red       = out_r[sdce_pkg::COLOR_W-1:0];
  assign res.green     = out_g[sdce_pkg::COLOR_W-1:0];
  assign res.blue      = out_b[sdce_pkg::COLOR_W-1:0];
  assign res.saturated = out_r[sdce_pkg::COLOR_W] | out_g[sdce_pkg::COLOR_W]
                         | out_b[sdce_pkg::COLOR_W];

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> (out_count < OCNT_W'(OUT_DEPTH)))
    else $error("result transfer with no free result slot");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= (OCNT_W + 1)'(OUT_DEPTH))
    else $error("reserved result slots exceed queue depth");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (v7 && s7_last) |=> (sum_red == '0 && sum_green == '0 && sum_blue == '0))
    else $error("accumulators not cleared after last term");

  a_fin_follows: assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> $past(v7))
    else $error("result without a term in the last stage");
endmodule
